FILE: rtl/spi9_pkg.sv
`timescale 1ns / 1ps
package spi9_pkg;

  // sizes
  localparam int MAX_PARAM_BYTES = 4;
  localparam int PAYLOAD_BYTES   = 4;
  localparam int BITS_PER_BYTE   = 8;
  localparam int WR_LIMIT_INT    = (MAX_PARAM_BYTES < PAYLOAD_BYTES) ?
                                   MAX_PARAM_BYTES : PAYLOAD_BYTES;

  localparam logic [2:0] WR_LIMIT = 3'(WR_LIMIT_INT);
  localparam logic [2:0] RD_LIMIT = 3'(PAYLOAD_BYTES);
  localparam logic [3:0] BIT_LAST = 4'(BITS_PER_BYTE);

  // input kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // result slot kinds
  localparam logic [1:0] SLOT_DC    = 2'd0;
  localparam logic [1:0] SLOT_DATA  = 2'd1;
  localparam logic [1:0] SLOT_RCLK  = 2'd2;
  localparam logic [1:0] SLOT_DONE  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [31:0] payload;
    logic [2:0]  byte_count;
    logic        miso_bit;
  } in_item_t;

  typedef struct packed {
    logic        mosi_bit;
    logic [1:0]  slot_kind;
    logic [31:0] read_data;
    logic        last;
  } out_item_t;

  // start of a write or read transaction, to transmitter and receiver
  typedef struct packed {
    logic        go;
    logic        is_read;
    logic [7:0]  command;
    logic [31:0] payload;
    logic [2:0]  count;
  } start_t;

  typedef enum logic [1:0] {
    TX_IDLE,
    TX_WORD,
    TX_READ_DONE
  } tx_state_t;

  // clamp a byte count to a limit
  function automatic logic [2:0] sat_count(input logic [2:0] count,
                                           input logic [2:0] limit);
    sat_count = (count > limit) ? limit : count;
  endfunction

endpackage

FILE: rtl/spi9_rx.sv
`timescale 1ns / 1ps
module spi9_rx import spi9_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  start_t    start,
  input  logic      sample,
  input  logic      miso,
  output logic      pending,
  output out_item_t result
);

  logic        skip;
  logic [5:0]  bits_left;
  logic [31:0] receive_shift;
  logic [31:0] shift_next;
  logic [2:0]  n_rd;

  assign n_rd       = sat_count(start.count, RD_LIMIT);
  assign shift_next = {receive_shift[30:0], miso};

  // result of one sample clock
  always_comb begin
    result = '0;
    if (skip) begin
      result.slot_kind = SLOT_RCLK;
    end else if (bits_left == 6'd1) begin
      result.slot_kind = SLOT_DONE;
      result.read_data = shift_next;
      result.last      = 1'b1;
    end else begin
      result.slot_kind = SLOT_RCLK;
    end
  end

  // receiver state: armed at transaction start, shifted per sample clock
  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      skip          <= 1'b0;
      bits_left     <= '0;
      receive_shift <= '0;
    end else if (start.go) begin
      receive_shift <= '0;
      if (start.is_read && n_rd != 3'd0) begin
        pending   <= 1'b1;
        bits_left <= {n_rd, 3'b000};
        skip      <= (n_rd > 3'd1);
      end else begin
        pending   <= 1'b0;
        bits_left <= '0;
        skip      <= 1'b0;
      end
    end else if (sample && pending) begin
      if (skip) begin
        skip <= 1'b0;
      end else if (bits_left == 6'd1) begin
        pending       <= 1'b0;
        bits_left     <= '0;
        receive_shift <= '0;
      end else begin
        receive_shift <= shift_next;
        bits_left     <= bits_left - 6'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pending_bits : assert property (@(posedge clk) disable iff (rst)
    pending |-> bits_left != 6'd0)
    else $error("receiver pending with no bits left");

  a_skip_multi : assert property (@(posedge clk) disable iff (rst)
    skip |-> (pending && bits_left > 6'd8))
    else $error("dummy clock armed for a single-byte read");
`endif

endmodule

FILE: rtl/spi9_tx.sv
`timescale 1ns / 1ps
module spi9_tx import spi9_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  start_t    start,
  input  logic      advance,
  output logic      busy,
  output out_item_t result
);

  tx_state_t   state, state_next;
  logic [39:0] shreg;
  logic [2:0]  words_left;
  logic [3:0]  bit_idx;
  logic        param;
  logic        is_read;
  logic        zero_read;
  logic [2:0]  n_wr;
  logic [2:0]  n_rd;
  logic [31:0] aligned;
  logic        word_end;

  assign n_wr     = sat_count(start.count, WR_LIMIT);
  assign n_rd     = sat_count(start.count, RD_LIMIT);
  assign busy     = (state != TX_IDLE);
  assign word_end = (bit_idx == BIT_LAST);

  // parameter bytes moved to the top of the shifter
  always_comb begin
    case (n_wr)
      3'd1:    aligned = {start.payload[7:0], 24'd0};
      3'd2:    aligned = {start.payload[15:0], 16'd0};
      3'd3:    aligned = {start.payload[23:0], 8'd0};
      3'd4:    aligned = start.payload;
      default: aligned = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      TX_IDLE: begin
        if (start.go) state_next = TX_WORD;
      end
      TX_WORD: begin
        if (advance && word_end && words_left == 3'd1) begin
          state_next = (is_read && zero_read) ? TX_READ_DONE : TX_IDLE;
        end
      end
      TX_READ_DONE: begin
        if (advance) state_next = TX_IDLE;
      end
      default: state_next = TX_IDLE;
    endcase
  end

  // slot output
  always_comb begin
    result = '0;
    case (state)
      TX_WORD: begin
        if (bit_idx == 4'd0) begin
          result.mosi_bit  = param;
          result.slot_kind = SLOT_DC;
        end else begin
          result.mosi_bit  = shreg[39];
          result.slot_kind = SLOT_DATA;
          result.last      = !is_read && words_left == 3'd1 && word_end;
        end
      end
      TX_READ_DONE: begin
        result.slot_kind = SLOT_DONE;
        result.last      = 1'b1;
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // word shifter and slot counters
  always_ff @(posedge clk) begin
    if (rst) begin
      words_left <= '0;
      bit_idx    <= '0;
      param      <= 1'b0;
      is_read    <= 1'b0;
      zero_read  <= 1'b0;
    end else if (state == TX_IDLE && start.go) begin
      shreg      <= {start.command, aligned};
      words_left <= start.is_read ? 3'd1 : n_wr + 3'd1;
      bit_idx    <= '0;
      param      <= 1'b0;
      is_read    <= start.is_read;
      zero_read  <= (n_rd == 3'd0);
    end else if (state == TX_WORD && advance) begin
      if (bit_idx == 4'd0) begin
        bit_idx <= 4'd1;
      end else begin
        shreg <= {shreg[38:0], 1'b0};
        if (word_end) begin
          bit_idx    <= '0;
          words_left <= words_left - 3'd1;
          param      <= 1'b1;
        end else begin
          bit_idx <= bit_idx + 4'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_word_counts : assert property (@(posedge clk) disable iff (rst)
    state == TX_WORD |-> (words_left != 3'd0 && bit_idx <= BIT_LAST))
    else $error("transmit counters out of range");
`endif

endmodule

FILE: rtl/spi_9bit_command_serializer.sv
`timescale 1ns / 1ps
// Write item: 9*(n+1) serial slots, one per cycle unless the output stalls.
// Next item is taken once the sequencer is back in idle after the last slot.
// Read start: 9 slots, plus one read-complete slot for a zero-byte read.
// Sample item: at most one result, registered on the accept edge; one per cycle unless stalled.
// Slot rate is set by the single 40-bit word shifter, which holds while the output stalls.
// Synchronous reset clears sequencer, receiver and output valid; no clearing pass.
module spi_9bit_command_serializer import spi9_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_ok;
  logic      accept;
  logic      sample;
  logic      tx_busy;
  logic      rx_pending;
  start_t    start;
  out_item_t tx_result;
  out_item_t rx_result;

  // handshake
  assign out_ok   = !out_valid || !out_stall;
  assign in_stall = tx_busy || !out_ok;
  assign accept   = in_valid && !in_stall;
  assign sample   = accept && in_data.kind == KIND_SAMPLE;

  always_comb begin
    start.go      = accept && (in_data.kind == KIND_WRITE || in_data.kind == KIND_READ);
    start.is_read = (in_data.kind == KIND_READ);
    start.command = in_data.command;
    start.payload = in_data.payload;
    start.count   = in_data.byte_count;
  end

  spi9_tx u_tx (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .advance (out_ok),
    .busy    (tx_busy),
    .result  (tx_result)
  );

  spi9_rx u_rx (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .sample  (sample),
    .miso    (in_data.miso_bit),
    .pending (rx_pending),
    .result  (rx_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ok) begin
      out_valid <= tx_busy || (sample && rx_pending);
    end
  end

  always_ff @(posedge clk) begin
    if (out_ok) begin
      out_data <= tx_busy ? tx_result : rx_result;
    end
  end

`ifndef SYNTHESIS
  a_done_is_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.slot_kind == SLOT_DONE) |-> out_data.last)
    else $error("read complete without end of transaction");

  a_rclk_mosi_low : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.slot_kind == SLOT_RCLK) |-> !out_data.mosi_bit && !out_data.last)
    else $error("read clock drives mosi or ends transaction");
`endif

endmodule
